/* rtl/assert_macros.svh */
// Assertion macros for the hash table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/oaht_pkg.sv */
// Shared types and constants for the hash table core.
package oaht_pkg;
	localparam int KEY_W = 31;

	typedef enum logic [2:0] {
		ST_INS_HOME = 3'd0,
		ST_INS_COLL = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISS     = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_QUAD   = 2'd1,
		MODE_DOUBLE = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_PROBE_MODE = 1'b1;

	typedef enum logic [3:0] {
		FS_IDLE, FS_HASH, FS_HASH2, FS_ADDR, FS_READ, FS_CHECK, FS_NEXT, FS_OUT
	} fsm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture key and command
		logic div_start; // start key mod S and key mod (S-1)
		logic init;      // set probe index zero, compute first slot
		logic step;      // advance probe index
		logic wr;        // write key into current slot
		logic fin_hit;   // finish: found or inserted
		logic fin_miss;  // finish: miss / full
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic is_insert;
		logic used;
		logic match;
		logic last;      // probe index is S-1
	} dp_stat_t;
endpackage

/* rtl/oaht_ram.sv */
// Generic single-port RAM with registered read.
module oaht_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* rtl/oaht_div.sv */
// Restoring divider: 31-bit dividend by 9-bit divisor, one bit per cycle.
module oaht_div import oaht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [8:0]       divisor,
	output logic             done,
	output logic [8:0]       remainder
);
	logic [KEY_W-1:0] num_q;
	logic [9:0]       rem_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [9:0]       trial;

	assign trial = {rem_q[8:0], num_q[KEY_W-1]};
	assign remainder = rem_q[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(KEY_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
		end
	end
endmodule

/* rtl/oaht_datapath.sv */
// Datapath: hashing, probe address generation, slot store and result registers.
module oaht_datapath import oaht_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic             command,
	input  logic [KEY_W-1:0] key,
	input  logic [8:0]       eff_size,
	input  mode_t            mode,
	output dp_stat_t         stat,
	output logic [2:0]       status,
	output logic [7:0]       position,
	output logic [7:0]       probes,
	output logic [7:0]       collision_count
);
	localparam int AW = $clog2(DEPTH);

	logic [KEY_W-1:0] key_q;
	logic             cmd_q;
	logic [8:0]       size_q;
	mode_t            mode_q;
	logic [8:0]       home_q, h2_q, i_q, slot_q, qinc_q;
	logic             second_q;
	logic             div_start_r, div_done;
	logic [8:0]       div_rem;
	logic [DEPTH-1:0] used_q;
	logic [KEY_W-1:0] rdata;
	logic [AW-1:0]    addr;
	logic [9:0]       inc, sum;
	logic [8:0]       next_slot;
	logic [7:0]       coll_q;

	oaht_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_r),
		.dividend(key_q), .divisor(second_q ? size_q - 9'd1 : size_q),
		.done(div_done), .remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_r <= 1'b0;
			second_q <= 1'b0;
		end else begin
			div_start_r <= cmd.div_start || (div_done && !second_q);
			if (cmd.div_start) second_q <= 1'b0;
			else if (div_done && !second_q) second_q <= 1'b1;
		end
	end

	// increment from probe i to i+1, each kept below S
	always_comb begin
		unique case (mode_q)
			MODE_QUAD:   inc = {1'b0, qinc_q};
			MODE_DOUBLE: inc = {1'b0, h2_q};
			default:     inc = 10'd1;
		endcase
		sum = {1'b0, slot_q} + inc;
		next_slot = (sum >= {1'b0, size_q}) ? 9'(sum - {1'b0, size_q}) : sum[8:0];
	end

	assign addr = AW'(slot_q);
	oaht_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_keys (
		.clk(clk), .we(cmd.wr), .addr(addr), .wdata(key_q), .rdata(rdata)
	);

	assign stat.div_done  = div_done && second_q;
	assign stat.is_insert = (cmd_q == CMD_INSERT);
	assign stat.used      = used_q[addr];
	assign stat.match     = (rdata == key_q);
	assign stat.last      = (i_q == size_q - 9'd1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			cmd_q <= command;
			size_q <= eff_size;
			mode_q <= mode;
		end
		if (div_done && !second_q) home_q <= div_rem;
		if (div_done && second_q) h2_q <= div_rem + 9'd1;
		if (cmd.init) begin
			i_q <= '0;
			slot_q <= home_q;
			qinc_q <= (size_q == 9'd2) ? 9'd0 : 9'd2; // (2i+2) mod S at i=0
		end else if (cmd.step) begin
			i_q <= i_q + 9'd1;
			slot_q <= next_slot;
			// qinc += 2 mod S
			if ({1'b0, qinc_q} + 10'd2 >= {1'b0, size_q})
				qinc_q <= 9'({1'b0, qinc_q} + 10'd2 - {1'b0, size_q});
			else
				qinc_q <= qinc_q + 9'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			coll_q <= '0;
			status <= '0;
			position <= '0;
			probes <= '0;
		end else begin
			if (cmd.wr) used_q[addr] <= 1'b1;
			if (cmd.fin_hit) begin
				position <= slot_q[7:0];
				probes <= i_q[7:0];
				if (cmd_q == CMD_SEARCH) status <= ST_FOUND;
				else if (i_q == '0) status <= ST_INS_HOME;
				else begin
					status <= ST_INS_COLL;
					coll_q <= i_q[7:0];
				end
			end else if (cmd.fin_miss) begin
				position <= '0;
				probes <= i_q[7:0];
				status <= (cmd_q == CMD_SEARCH) ? ST_MISS : ST_FULL;
			end
		end
	end
	assign collision_count = coll_q;
endmodule

/* rtl/oaht_ctrl.sv */
// Controller state machine sequencing one operation at a time.
module oaht_ctrl import oaht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = FS_HASH;
				end
			end
			FS_HASH: begin
				cmd.div_start = 1'b1;
				state_d = FS_HASH2;
			end
			FS_HASH2: if (stat.div_done) state_d = FS_ADDR;
			FS_ADDR: begin
				cmd.init = 1'b1;
				state_d = FS_READ;
			end
			FS_READ: state_d = FS_CHECK; // RAM read in flight
			FS_CHECK: begin
				state_d = FS_OUT;
				if (!stat.used) begin
					if (stat.is_insert) begin
						cmd.wr = 1'b1;
						cmd.fin_hit = 1'b1;
					end else cmd.fin_miss = 1'b1;
				end else if (!stat.is_insert && stat.match) cmd.fin_hit = 1'b1;
				else if (stat.last) cmd.fin_miss = 1'b1;
				else state_d = FS_NEXT;
			end
			FS_NEXT: begin
				cmd.step = 1'b1;
				state_d = FS_READ;
			end
			FS_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end
endmodule

/* rtl/open_addressing_hash_table_core.sv */
// Top level of the open-addressing hash table core.
//
//  channel | signals                                  | transfer when
//  in      | in_valid, command, key                   | in_valid && !in_stall
//  out     | out_valid, status, position, probes, ... | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data              | cfg_we
//
// One operation at a time: hashing (two 31-step remainders on the shared
// bit-serial divider), then a READ and CHECK pass through the key RAM per probe,
// with NEXT between probes. The result is registered and held in OUT; with no
// output stall the next input transfer can follow once the controller is in IDLE.
// Reset clears occupancy bits and the collision register, and sets configuration to size 256, linear probing.
// Stalls on the output hold the result; stalls on input only delay acceptance.
`include "assert_macros.svh"
module open_addressing_hash_table_core import oaht_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic [KEY_W-1:0] key,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [7:0]       position,
	output logic [7:0]       probes,
	output logic [7:0]       collision_count,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [8:0]       cfg_data
);
	localparam int LIMIT = (DEPTH < 256) ? DEPTH : 256;

	logic [8:0] size_q;
	mode_t      mode_q;
	logic [8:0] eff_size;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic       res_wait;

	// Index is one bit wide: both registers decode; nothing beyond them exists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 9'd256;
			mode_q <= MODE_LINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_SIZE: size_q <= cfg_data;
				CFG_PROBE_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// saturate to 2 .. LIMIT
	always_comb begin
		if (size_q < 9'd2) eff_size = 9'd2;
		else if (size_q > 9'(LIMIT)) eff_size = 9'(LIMIT);
		else eff_size = size_q;
	end

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	oaht_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .command(command), .key(key),
		.eff_size(eff_size), .mode(mode_q), .stat(stat), .status(status),
		.position(position), .probes(probes), .collision_count(collision_count)
	);

	// result waiting on a stalled receiver
	assign res_wait = out_valid && out_stall;

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall, "input open while busy")
	`ASSERT_NEXT(a_out_holds, clk, arst_n, res_wait, out_valid && $stable(status), "result dropped")
	`ASSERT_IMPL(a_one_finish, clk, arst_n, 1'b1, !(cmd.fin_hit && cmd.fin_miss), "two finishes")
endmodule
